[design/svd_2x2_rotation_angles_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef SVD_2X2_ROTATION_ANGLES_MACROS_SVH
`define SVD_2X2_ROTATION_ANGLES_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SVD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked from a clock edge, the consequent delayed by the DLY argument.
`define SVD_ASSERT_AFTER(lbl, clk, rst, ante, DLY, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##DLY (cons)) \
      else $error(msg);

`endif

[design/svd2r_pkg.sv]
`timescale 1ns / 1ps
package svd2r_pkg;

   // Datapath widths
   localparam int ENTRY_W  = 17;   // matrix entry after extension
   localparam int PROD_W   = 34;   // entry times entry
   localparam int SUM_W    = 36;   // atan2 operands
   localparam int VEC_W    = 44;   // vectoring x/y after normalization
   localparam int ANG_W    = 35;   // Q30 angle accumulator, atan2 side
   localparam int ROT_ZW   = 34;   // Q30 residual angle, sin/cos side
   localparam int TRIG_W   = 34;   // Q30 cos/sin
   localparam int PART_W   = 26;   // inner products rounded to Q20
   localparam int NORM_LOG = 40;   // normalize until x or |y| reaches 2^40
   localparam int ANGLE_W  = 16;
   localparam int SIGMA_W  = 17;

   localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic [SIGMA_W-1:0] SIGMA_MAX = 17'd131071;

   // atan(2^-i) in Q30
   localparam logic [29:0] ATAN_Q30 [32] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
      30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
      30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
      30'd262144,    30'd131072,    30'd65536,     30'd32768,
      30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,
      30'd64,        30'd32,        30'd16,        30'd8,
      30'd4,         30'd2,         30'd1,         30'd0
   };

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] left_angle;
      logic signed [ANGLE_W-1:0] right_angle;
      logic [SIGMA_W-1:0]        sigma_first;
      logic [SIGMA_W-1:0]        sigma_second;
      logic                      neg_first;
      logic                      neg_second;
   } rsp_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] a00;
      logic signed [ENTRY_W-1:0] a01;
      logic signed [ENTRY_W-1:0] a10;
      logic signed [ENTRY_W-1:0] a11;
   } ent_type;

   // State handed from one vectoring cell to the next
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } vec_type;

   // State handed from one rotation cell to the next
   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [ROT_ZW-1:0] z;
   } rot_type;

   // Shift-subtract divide, used only for elaboration-time constants
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Q30 inverse gain of the first stages rotations, square root rounded to nearest
   function automatic logic [63:0] gain_q30(input int stages);
      logic [63:0] k2;
      logic [63:0] r;
      logic [63:0] bit_v;
      logic [63:0] v;
      int          n;
      k2    = 64'd1 << 60;
      r     = '0;
      bit_v = 64'd1 << 62;
      n     = (stages > 32) ? 32 : stages;
      for (int i = 0; i < n; i++) begin
         k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
      end
      v = k2;
      while (bit_v > v) begin
         bit_v = bit_v >> 2;
      end
      while (bit_v != 0) begin
         if (v >= r + bit_v) begin
            v = v - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      if (v > r) begin
         r = r + 64'd1;
      end
      return r;
   endfunction

endpackage

[design/svd_2x2_rotation_angles.sv]
`timescale 1ns / 1ps
// Closed-form SVD of a 2x2 matrix in Q2.14: rotation angles of U and W and
// the two singular values with their sign bits.
// Request channel: req_data is taken at a clock edge where start is high and
// busy is low. busy never rises, so one request can enter every cycle.
// Result channel: rsp_data is valid for exactly one cycle while rsp_strobe is
// high; the receiver must take it then, there is no back-pressure.
// The pipeline is two rows of CORDIC cells in series (atan2, then sin/cos)
// plus product, sum, normalize and rounding stages. Throughput is one request
// per cycle, results leave in request order.
// Reset clears the valid pipeline only, so requests in flight are dropped and
// no strobe appears until a new request has gone through.
module svd_2x2_rotation_angles #(
   parameter int ENTRY_BITS      = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  svd2r_pkg::req_type req_data,
   output logic               busy,
   output logic               rsp_strobe,
   output svd2r_pkg::rsp_type rsp_data
);
   import svd2r_pkg::*;
   `include "svd_2x2_rotation_angles_macros.svh"

   localparam int N       = ROTATION_STAGES;
   localparam int LAT     = 2 * N + 10;
   localparam int ENT_DLY = 2 * N + 5;
   localparam int ANG_DLY = N + 3;
   localparam int MUL_W   = ENTRY_W + TRIG_W;
   localparam int PSUM_W  = MUL_W + 1;
   localparam int DMUL_W  = TRIG_W + PART_W;
   localparam int T_W     = DMUL_W + 1;

   localparam logic signed [PSUM_W-1:0] HALF_24 = PSUM_W'(1) << 23;
   localparam logic signed [T_W-1:0]    HALF_36 = T_W'(1) << 35;
   localparam logic signed [ANG_W-1:0]  HALF_17 = ANG_W'(1) << 16;

   logic accept;

   ent_type                  ent_ff;
   ent_type                  ent_dly_ff [0:ENT_DLY-1];
   logic signed [PROD_W-1:0] q0010_ff, q0111_ff, q0000_ff, q0101_ff;
   logic signed [PROD_W-1:0] q1010_ff, q1111_ff, q0001_ff, q1011_ff;
   logic signed [SUM_W-1:0]  yt_ff, xt_ff, yp_ff, xp_ff;

   logic signed [ANG_W-1:0]  zt, zp;
   logic signed [TRIG_W-1:0] cu, su, cw, sw;
   logic signed [TRIG_W-1:0] cu_p_ff, su_p_ff, cu_q_ff, su_q_ff;
   logic signed [ANGLE_W-1:0] left_dly_ff  [0:ANG_DLY-1];
   logic signed [ANGLE_W-1:0] right_dly_ff [0:ANG_DLY-1];

   logic signed [MUL_W-1:0]  r00c_ff, r01s_ff, r10c_ff, r11s_ff;
   logic signed [MUL_W-1:0]  r01c_ff, r00s_ff, r11c_ff, r10s_ff;
   logic signed [PART_W-1:0] p1a_ff, p2a_ff, p1b_ff, p2b_ff;
   logic signed [DMUL_W-1:0] ta1_ff, ta2_ff, tb1_ff, tb2_ff;
   logic signed [T_W-1:0]    ta, tb;

   logic [LAT-1:0] vld_in;
   logic [LAT-1:0] vld_ff;
   rsp_type        rsp_in;
   rsp_type        rsp_ff;

   // sign-extend from ENTRY_BITS; wider settings leave the entry non-negative
   function automatic logic signed [ENTRY_W-1:0] to_entry(input logic [15:0] raw);
      logic [15:0] mask;
      logic [15:0] v;
      logic        sgn;
      mask = (ENTRY_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ENTRY_BITS) - 32'd1);
      v    = raw & mask;
      sgn  = (ENTRY_BITS <= 16) ? v[4'(ENTRY_BITS - 1)] : 1'b0;
      return sgn ? ({1'b0, v} | ~{1'b0, mask}) : {1'b0, v};
   endfunction

   function automatic logic signed [ANGLE_W-1:0] round_angle(
      input logic signed [ANG_W-1:0] z);
      logic signed [ANG_W-1:0] r;
      r = (z + HALF_17) >>> 17;
      return r[ANGLE_W-1:0];
   endfunction

   // round Q50 to Q14, magnitude, saturate
   function automatic logic [SIGMA_W-1:0] sigma_of(input logic signed [T_W-1:0] t);
      logic signed [T_W-1:0] r;
      logic signed [T_W-1:0] m;
      r = (t + HALF_36) >>> 36;
      m = (r < 0) ? -r : r;
      return (m > T_W'(SIGMA_MAX)) ? SIGMA_MAX : m[SIGMA_W-1:0];
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // entries, then their products, then the atan2 operands
   always_ff @(posedge clock) begin
      ent_ff.a00 <= to_entry(req_data.m00);
      ent_ff.a01 <= to_entry(req_data.m01);
      ent_ff.a10 <= to_entry(req_data.m10);
      ent_ff.a11 <= to_entry(req_data.m11);

      q0010_ff <= ent_ff.a00 * ent_ff.a10;
      q0111_ff <= ent_ff.a01 * ent_ff.a11;
      q0000_ff <= ent_ff.a00 * ent_ff.a00;
      q0101_ff <= ent_ff.a01 * ent_ff.a01;
      q1010_ff <= ent_ff.a10 * ent_ff.a10;
      q1111_ff <= ent_ff.a11 * ent_ff.a11;
      q0001_ff <= ent_ff.a00 * ent_ff.a01;
      q1011_ff <= ent_ff.a10 * ent_ff.a11;

      yt_ff <= (SUM_W'(q0010_ff) + SUM_W'(q0111_ff)) <<< 1;
      xt_ff <= (SUM_W'(q0000_ff) + SUM_W'(q0101_ff))
               - (SUM_W'(q1010_ff) + SUM_W'(q1111_ff));
      yp_ff <= (SUM_W'(q0001_ff) + SUM_W'(q1011_ff)) <<< 1;
      xp_ff <= (SUM_W'(q0000_ff) + SUM_W'(q1010_ff))
               - (SUM_W'(q0101_ff) + SUM_W'(q1111_ff));
   end

   svd2r_atan2 #(.STAGES(N)) u_atan_left (
      .clock (clock),
      .num_y (yt_ff),
      .den_x (xt_ff),
      .angle (zt)
   );

   svd2r_atan2 #(.STAGES(N)) u_atan_right (
      .clock (clock),
      .num_y (yp_ff),
      .den_x (xp_ff),
      .angle (zp)
   );

   // half angles into sin/cos
   svd2r_sincos #(.STAGES(N)) u_trig_left (
      .clock   (clock),
      .angle   (ROT_ZW'(zt >>> 1)),
      .cos_out (cu),
      .sin_out (su)
   );

   svd2r_sincos #(.STAGES(N)) u_trig_right (
      .clock   (clock),
      .angle   (ROT_ZW'(zp >>> 1)),
      .cos_out (cw),
      .sin_out (sw)
   );

   // entries and output angles wait for the trig rows
   always_ff @(posedge clock) begin
      ent_dly_ff[0]   <= ent_ff;
      left_dly_ff[0]  <= round_angle(zt);
      right_dly_ff[0] <= round_angle(zp);
      for (int k = 1; k < ENT_DLY; k++) begin
         ent_dly_ff[k] <= ent_dly_ff[k-1];
      end
      for (int k = 1; k < ANG_DLY; k++) begin
         left_dly_ff[k]  <= left_dly_ff[k-1];
         right_dly_ff[k] <= right_dly_ff[k-1];
      end
   end

   // A*W: products, then rounded inner products; U^T*(A*W): products
   always_ff @(posedge clock) begin
      r00c_ff <= ent_dly_ff[ENT_DLY-1].a00 * cw;
      r01s_ff <= ent_dly_ff[ENT_DLY-1].a01 * sw;
      r10c_ff <= ent_dly_ff[ENT_DLY-1].a10 * cw;
      r11s_ff <= ent_dly_ff[ENT_DLY-1].a11 * sw;
      r01c_ff <= ent_dly_ff[ENT_DLY-1].a01 * cw;
      r00s_ff <= ent_dly_ff[ENT_DLY-1].a00 * sw;
      r11c_ff <= ent_dly_ff[ENT_DLY-1].a11 * cw;
      r10s_ff <= ent_dly_ff[ENT_DLY-1].a10 * sw;
      cu_p_ff <= cu;
      su_p_ff <= su;

      p1a_ff  <= PART_W'((PSUM_W'(r00c_ff) + PSUM_W'(r01s_ff) + HALF_24) >>> 24);
      p2a_ff  <= PART_W'((PSUM_W'(r10c_ff) + PSUM_W'(r11s_ff) + HALF_24) >>> 24);
      p1b_ff  <= PART_W'((PSUM_W'(r01c_ff) - PSUM_W'(r00s_ff) + HALF_24) >>> 24);
      p2b_ff  <= PART_W'((PSUM_W'(r11c_ff) - PSUM_W'(r10s_ff) + HALF_24) >>> 24);
      cu_q_ff <= cu_p_ff;
      su_q_ff <= su_p_ff;

      ta1_ff <= cu_q_ff * p1a_ff;
      ta2_ff <= su_q_ff * p2a_ff;
      tb1_ff <= cu_q_ff * p2b_ff;
      tb2_ff <= su_q_ff * p1b_ff;
   end

   // diagonal of U^T*A*W
   assign ta = T_W'(ta1_ff) + T_W'(ta2_ff);
   assign tb = T_W'(tb1_ff) - T_W'(tb2_ff);

   always_comb begin
      rsp_in.left_angle   = left_dly_ff[ANG_DLY-1];
      rsp_in.right_angle  = right_dly_ff[ANG_DLY-1];
      rsp_in.sigma_first  = sigma_of(ta);
      rsp_in.sigma_second = sigma_of(tb);
      rsp_in.neg_first    = ta < 0;
      rsp_in.neg_second   = tb < 0;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // request valid follows the data down the pipe
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_strobe = vld_ff[LAT-1];
   assign rsp_data   = rsp_ff;

   `SVD_ASSERT_AFTER(a_latency, clock, reset, accept, LAT, rsp_strobe, "result strobe missing")
   `SVD_ASSERT_AFTER(a_zero_matrix, clock, reset, accept && req_data == '0, LAT, rsp_data == '0, "zero matrix gave nonzero result")
   `SVD_ASSERT_ALWAYS(a_left_clamp, clock, reset, !vld_ff[ANG_DLY+2] || (zt <= PI_Q30 && zt >= -PI_Q30), "left atan2 out of range")
   `SVD_ASSERT_ALWAYS(a_angle_range, clock, reset, !rsp_strobe || (rsp_data.right_angle <= 16'sd25736 && rsp_data.right_angle >= -16'sd25736), "right angle out of range")

endmodule

[design/svd2r_vec_cell.sv]
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation, registered
module svd2r_vec_cell #(
   parameter int SHIFT = 0
) (
   input  logic               clock,
   input  svd2r_pkg::vec_type up_data,
   output svd2r_pkg::vec_type dn_data
);
   import svd2r_pkg::*;

   localparam logic signed [ANG_W-1:0] STEP_ANGLE =
      {{(ANG_W-30){1'b0}}, ATAN_Q30[5'(SHIFT)]};

   vec_type stage_in;
   vec_type stage_ff;

   // drive y toward zero
   always_comb begin
      if (up_data.y > 0) begin
         stage_in.x = up_data.x + (up_data.y >>> SHIFT);
         stage_in.y = up_data.y - (up_data.x >>> SHIFT);
         stage_in.z = up_data.z + STEP_ANGLE;
      end else begin
         stage_in.x = up_data.x - (up_data.y >>> SHIFT);
         stage_in.y = up_data.y + (up_data.x >>> SHIFT);
         stage_in.z = up_data.z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign dn_data = stage_ff;

endmodule

[design/svd2r_rot_cell.sv]
`timescale 1ns / 1ps
// One rotation-mode CORDIC micro-rotation, registered
module svd2r_rot_cell #(
   parameter int SHIFT = 0
) (
   input  logic               clock,
   input  svd2r_pkg::rot_type up_data,
   output svd2r_pkg::rot_type dn_data
);
   import svd2r_pkg::*;

   localparam logic signed [ROT_ZW-1:0] STEP_ANGLE =
      {{(ROT_ZW-30){1'b0}}, ATAN_Q30[5'(SHIFT)]};

   rot_type stage_in;
   rot_type stage_ff;

   // drive residual angle toward zero
   always_comb begin
      if (up_data.z >= 0) begin
         stage_in.x = up_data.x - (up_data.y >>> SHIFT);
         stage_in.y = up_data.y + (up_data.x >>> SHIFT);
         stage_in.z = up_data.z - STEP_ANGLE;
      end else begin
         stage_in.x = up_data.x + (up_data.y >>> SHIFT);
         stage_in.y = up_data.y - (up_data.x >>> SHIFT);
         stage_in.z = up_data.z + STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign dn_data = stage_ff;

endmodule

[design/svd2r_atan2.sv]
`timescale 1ns / 1ps
// Pipelined atan2: quadrant fold, two normalize stages, a row of vectoring
// cells and a clamp stage.
module svd2r_atan2 #(
   parameter int STAGES = 16
) (
   input  logic                                   clock,
   input  logic signed [svd2r_pkg::SUM_W-1:0]     num_y,
   input  logic signed [svd2r_pkg::SUM_W-1:0]     den_x,
   output logic signed [svd2r_pkg::ANG_W-1:0]     angle
);
   import svd2r_pkg::*;

   vec_type                  n1_in;
   vec_type                  n1_ff;
   vec_type                  n2_in;
   vec_type                  n2_ff;
   logic                     zero_in;
   logic [STAGES+1:0]        zero_ff;
   vec_type                  link [0:STAGES];
   logic signed [ANG_W-1:0]  angle_in;
   logic signed [ANG_W-1:0]  angle_ff;

   // shift left by sh when both stay inside the normalize limit
   function automatic vec_type norm_step(input vec_type v, input int sh);
      logic signed [VEC_W-1:0] lim;
      vec_type                 r;
      lim = VEC_W'(1) << (NORM_LOG - sh);
      r   = v;
      if (v.x < lim && v.y < lim && v.y > -lim) begin
         r.x = v.x <<< sh;
         r.y = v.y <<< sh;
      end
      return r;
   endfunction

   // fold left half-plane, coarse normalize
   always_comb begin
      zero_in = (den_x == '0) && (num_y == '0);
      if (den_x < 0) begin
         n1_in.x = VEC_W'(-den_x);
         n1_in.y = VEC_W'(-num_y);
         n1_in.z = (num_y >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         n1_in.x = VEC_W'(den_x);
         n1_in.y = VEC_W'(num_y);
         n1_in.z = '0;
      end
      n1_in = norm_step(n1_in, 32);
      n1_in = norm_step(n1_in, 16);
      n1_in = norm_step(n1_in, 8);
   end

   // fine normalize; the operands start below the limit, so one more doubling
   always_comb begin
      n2_in   = norm_step(n1_ff, 4);
      n2_in   = norm_step(n2_in, 2);
      n2_in   = norm_step(n2_in, 1);
      n2_in.x = n2_in.x <<< 1;
      n2_in.y = n2_in.y <<< 1;
   end

   always_ff @(posedge clock) begin
      n1_ff      <= n1_in;
      n2_ff      <= n2_in;
      zero_ff[0] <= zero_in;
      for (int k = 1; k <= STAGES + 1; k++) begin
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   assign link[0] = n2_ff;

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      svd2r_vec_cell #(.SHIFT(g)) u_cell (
         .clock   (clock),
         .up_data (link[g]),
         .dn_data (link[g+1])
      );
   end

   // clamp to [-pi, pi]; zero vector gives zero
   always_comb begin
      if (zero_ff[STAGES+1]) begin
         angle_in = '0;
      end else if (link[STAGES].z > PI_Q30) begin
         angle_in = PI_Q30;
      end else if (link[STAGES].z < -PI_Q30) begin
         angle_in = -PI_Q30;
      end else begin
         angle_in = link[STAGES].z;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

[design/svd2r_sincos.sv]
`timescale 1ns / 1ps
// Row of rotation cells giving cos and sin in Q30.
module svd2r_sincos #(
   parameter int STAGES = 16
) (
   input  logic                                  clock,
   input  logic signed [svd2r_pkg::ROT_ZW-1:0]   angle,
   output logic signed [svd2r_pkg::TRIG_W-1:0]   cos_out,
   output logic signed [svd2r_pkg::TRIG_W-1:0]   sin_out
);
   import svd2r_pkg::*;

   localparam logic [63:0] GAIN_FULL = gain_q30(STAGES);
   localparam logic signed [TRIG_W-1:0] GAIN = GAIN_FULL[TRIG_W-1:0];

   rot_type link [0:STAGES];

   // start on the x axis scaled by the row's inverse gain
   assign link[0].x = GAIN;
   assign link[0].y = '0;
   assign link[0].z = angle;

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      svd2r_rot_cell #(.SHIFT(g)) u_cell (
         .clock   (clock),
         .up_data (link[g]),
         .dn_data (link[g+1])
      );
   end

   assign cos_out = link[STAGES].x;
   assign sin_out = link[STAGES].y;

endmodule
